// ===== rtl/core/eia_pkg.sv =====
// Shared constants, types and helper functions of the identifier allocator.
`timescale 1ns / 1ps

package eia_pkg;

    localparam int ID_SPACE   = 256;
    localparam int TARGET_W   = 8;
    localparam int GRANT_W    = 9;
    localparam int LIVE_W     = 9;
    localparam int WORD_W     = 64;
    localparam int POS_W      = 6;
    localparam int BYTE_SEL_W = 3;
    localparam int NUM_WORDS  = (ID_SPACE + WORD_W - 1) / WORD_W;
    localparam int WIDX_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W      = WIDX_W + POS_W;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        ST_CREATED = 2'd0,
        ST_FULL    = 2'd1,
        ST_DELETED = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    typedef logic [WORD_W-1:0] word_t;

    // Outcome of one pass of the word scanner.
    typedef struct packed {
        logic             zero_hit;
        logic [POS_W-1:0] zero_pos;
        logic             one_hit;
    } scan_res_t;

    // Lowest set bit of an 8-bit vector; zero when nothing is set.
    function automatic logic [BYTE_SEL_W-1:0] lowest_set8(input logic [7:0] v);
        logic [BYTE_SEL_W-1:0] pos;
        pos = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = BYTE_SEL_W'(i);
            end
        end
        return pos;
    endfunction

    // Bits of a bitmap word that stand for identifiers inside the space.
    function automatic word_t valid_mask(input logic [WIDX_W-1:0] widx);
        word_t m;
        for (int b = 0; b < WORD_W; b++)
        begin
            m[b] = ((int'(widx) * WORD_W + b) < ID_SPACE);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/eia_word_scan.sv =====
// Shared scanner: finds the lowest free bit and any used bit of one masked bitmap word.
`timescale 1ns / 1ps

module eia_word_scan (
    input  eia_pkg::word_t     word,
    input  eia_pkg::word_t     mask,
    output eia_pkg::scan_res_t res
);

    eia_pkg::word_t                     free_bits;
    logic [7:0]                         byte_flags;
    logic [eia_pkg::BYTE_SEL_W-1:0]     byte_sel;
    logic [7:0]                         byte_bits;
    logic [eia_pkg::BYTE_SEL_W-1:0]     bit_sel;

    assign free_bits = ~word & mask;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_flags[i] = |free_bits[i*8 +: 8];
        end
    end

    // Two short priority steps: first the byte, then the bit inside it.
    assign byte_sel  = eia_pkg::lowest_set8(byte_flags);
    assign byte_bits = free_bits[byte_sel*8 +: 8];
    assign bit_sel   = eia_pkg::lowest_set8(byte_bits);

    assign res.zero_hit = |byte_flags;
    assign res.zero_pos = {byte_sel, bit_sel};
    assign res.one_hit  = |(word & mask);

endmodule

// ===== rtl/core/entity_id_allocator_top.sv =====
// Top level of the lowest-free identifier allocator: sequencer, bitmap and output register.
`timescale 1ns / 1ps
//
// Usage: each input beat is one request. s_axis_tuser selects the action
// (0 create, 1 delete) and s_axis_tdata carries the identifier to delete.
// Each request yields exactly one output beat holding the granted identifier
// (256 when none is handed out), a status code and the live count after the
// request.
// Timing: the block takes one request at a time and drops s_axis_tready
// until the result is loaded into the output register. A create served from
// the fresh counter, a full create and any absent delete pass from the decide
// state straight to the emit state. A create that searches for a freed
// identifier, or a delete that must check for higher live identifiers,
// walks the bitmap one 64-bit word per cycle through the shared word
// scanner before it reaches the emit state.
// The output register lets the next request be taken while a result waits.
// Reset clears the bitmap, the fresh counter and the live count at once;
// no clearing pass is needed. If the receiver stalls, the result holds in
// the output register and a finished next result waits until it drains.
//
module entity_id_allocator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: target_id[7:0]
    input  logic [eia_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: action[0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: granted_id[8:0], status[10:9], live_total[19:11], zero pad[23:20]
    output logic [eia_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN_FREE,
        S_SCAN_HIGH,
        S_EMIT
    } state_t;

    state_t                               state_reg, state_next;
    eia_pkg::word_t                       map_reg  [eia_pkg::NUM_WORDS];
    eia_pkg::word_t                       map_next [eia_pkg::NUM_WORDS];
    logic [eia_pkg::LIVE_W-1:0]           fresh_reg, fresh_next;
    logic [eia_pkg::LIVE_W-1:0]           live_reg, live_next;
    logic                                 action_reg, action_next;
    logic [eia_pkg::TARGET_W-1:0]         target_reg, target_next;
    logic [eia_pkg::WIDX_W-1:0]           widx_reg, widx_next;
    logic [eia_pkg::GRANT_W-1:0]          grant_reg, grant_next;
    eia_pkg::status_t                     status_reg, status_next;
    logic                                 out_valid_reg, out_valid_next;
    logic [eia_pkg::OUT_DATA_W-1:0]       out_data_reg, out_data_next;

    logic [eia_pkg::IDX_W-1:0]            fresh_idx;
    logic [eia_pkg::IDX_W-1:0]            target_idx;
    logic                                 target_in_space;
    eia_pkg::word_t                       scan_word;
    eia_pkg::word_t                       scan_mask;
    eia_pkg::scan_res_t                   scan_res;
    logic                                 last_word;

    localparam logic [eia_pkg::GRANT_W-1:0] NONE_ID = eia_pkg::GRANT_W'(eia_pkg::ID_SPACE);
    localparam logic [eia_pkg::LIVE_W-1:0]  SPACE_CNT = eia_pkg::LIVE_W'(eia_pkg::ID_SPACE);
    localparam logic [eia_pkg::WIDX_W-1:0]  LAST_WIDX = eia_pkg::WIDX_W'(eia_pkg::NUM_WORDS - 1);

    assign fresh_idx       = eia_pkg::IDX_W'(fresh_reg);
    assign target_idx      = eia_pkg::IDX_W'(target_reg);
    assign target_in_space = ({1'b0, target_reg} < SPACE_CNT);
    assign last_word       = (widx_reg == LAST_WIDX);

    // The scanner looks at the word under widx_reg. For the higher-use check,
    // the target's own word is masked down to the bits above the target.
    assign scan_word = map_reg[widx_reg];

    always_comb
    begin
        scan_mask = eia_pkg::valid_mask(widx_reg);
        if (state_reg == S_SCAN_HIGH && widx_reg == target_idx[eia_pkg::POS_W +: eia_pkg::WIDX_W])
        begin
            scan_mask = scan_mask & (({eia_pkg::WORD_W{1'b1}}
                                      << target_idx[eia_pkg::POS_W-1:0]) << 1);
        end
    end

    eia_word_scan u_scan (
        .word (scan_word),
        .mask (scan_mask),
        .res  (scan_res)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        map_next       = map_reg;
        fresh_next     = fresh_reg;
        live_next      = live_reg;
        action_next    = action_reg;
        target_next    = target_reg;
        widx_next      = widx_reg;
        grant_next     = grant_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    action_next = s_axis_tuser;
                    target_next = s_axis_tdata[eia_pkg::TARGET_W-1:0];
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                grant_next = NONE_ID;
                state_next = S_EMIT;
                if (!action_reg)
                begin
                    if (fresh_reg < SPACE_CNT)
                    begin
                        if (!map_reg[fresh_idx[eia_pkg::POS_W +: eia_pkg::WIDX_W]]
                                    [fresh_idx[eia_pkg::POS_W-1:0]])
                        begin
                            map_next[fresh_idx[eia_pkg::POS_W +: eia_pkg::WIDX_W]]
                                    [fresh_idx[eia_pkg::POS_W-1:0]] = 1'b1;
                            live_next = live_reg + 1'b1;
                        end
                        fresh_next  = fresh_reg + 1'b1;
                        grant_next  = fresh_reg;
                        status_next = eia_pkg::ST_CREATED;
                    end
                    else if (live_reg < SPACE_CNT)
                    begin
                        widx_next  = '0;
                        state_next = S_SCAN_FREE;
                    end
                    else
                    begin
                        status_next = eia_pkg::ST_FULL;
                    end
                end
                else if (!target_in_space
                         || !map_reg[target_idx[eia_pkg::POS_W +: eia_pkg::WIDX_W]]
                                    [target_idx[eia_pkg::POS_W-1:0]])
                begin
                    status_next = eia_pkg::ST_ABSENT;
                end
                else
                begin
                    widx_next  = target_idx[eia_pkg::POS_W +: eia_pkg::WIDX_W];
                    state_next = S_SCAN_HIGH;
                end
            end
            S_SCAN_FREE:
            begin
                if (scan_res.zero_hit)
                begin
                    map_next[widx_reg][scan_res.zero_pos] = 1'b1;
                    live_next   = live_reg + 1'b1;
                    grant_next  = eia_pkg::GRANT_W'({widx_reg, scan_res.zero_pos});
                    status_next = eia_pkg::ST_CREATED;
                    state_next  = S_EMIT;
                end
                else if (last_word)
                begin
                    grant_next  = NONE_ID;
                    status_next = eia_pkg::ST_FULL;
                    state_next  = S_EMIT;
                end
                else
                begin
                    widx_next = widx_reg + 1'b1;
                end
            end
            S_SCAN_HIGH:
            begin
                if (scan_res.one_hit || last_word)
                begin
                    if (!scan_res.one_hit && fresh_reg != '0)
                    begin
                        fresh_next = fresh_reg - 1'b1;
                    end
                    map_next[target_idx[eia_pkg::POS_W +: eia_pkg::WIDX_W]]
                            [target_idx[eia_pkg::POS_W-1:0]] = 1'b0;
                    if (live_reg != '0)
                    begin
                        live_next = live_reg - 1'b1;
                    end
                    grant_next  = NONE_ID;
                    status_next = eia_pkg::ST_DELETED;
                    state_next  = S_EMIT;
                end
                else
                begin
                    widx_next = widx_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                // The live count register already holds the value after this request.
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = eia_pkg::OUT_DATA_W'({live_reg, status_reg, grant_reg});
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int w = 0; w < eia_pkg::NUM_WORDS; w++)
            begin
                map_reg[w] <= '0;
            end
            fresh_reg     <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            map_reg       <= map_next;
            fresh_reg     <= fresh_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        target_reg   <= target_next;
        widx_reg     <= widx_next;
        grant_reg    <= grant_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg <= SPACE_CNT) && (fresh_reg <= SPACE_CNT))
        else $error("live count or fresh counter beyond identifier space");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[10:9] == eia_pkg::ST_CREATED)
        |-> (m_axis_tdata[19:11] != '0 && m_axis_tdata[8:0] != NONE_ID))
        else $error("create result without a granted identifier");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[10:9] != eia_pkg::ST_CREATED)
        |-> (m_axis_tdata[8:0] == NONE_ID))
        else $error("identifier reported on a non-create result");
`endif

endmodule

// ===== test/tb_entity_id_allocator_top.sv =====
// Self-checking testbench of the identifier allocator: predicts each result beat and compares it.
`timescale 1ns / 1ps

module tb_entity_id_allocator_top;

    localparam logic ACT_CREATE = 1'b0;
    localparam logic ACT_DELETE = 1'b1;
    localparam int   STALL_LIMIT = 5000;
    localparam int   DRAIN_CYCLES = 12;

    typedef struct {
        logic [eia_pkg::GRANT_W-1:0] granted;
        eia_pkg::status_t            status;
        logic [eia_pkg::LIVE_W-1:0]  live;
    } alloc_result_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [eia_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [eia_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Predicted allocator state.
    logic [eia_pkg::ID_SPACE-1:0]   id_taken;
    logic [eia_pkg::GRANT_W-1:0]    next_fresh;
    logic [eia_pkg::LIVE_W-1:0]     live_cnt;

    alloc_result_t         pending_results[$];
    int                    error_count = 0;
    int                    send_idle_pct = 0;
    int                    recv_idle_pct = 0;
    int                    quiet_cycles = 0;

    entity_id_allocator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic alloc_result_t predict_allocation(
        input logic act,
        input logic [eia_pkg::TARGET_W-1:0] target);
        alloc_result_t r;
        logic          found;
        logic          higher;
        r.granted = eia_pkg::GRANT_W'(eia_pkg::ID_SPACE);
        r.status  = eia_pkg::ST_FULL;
        if (act == ACT_CREATE)
        begin
            if (next_fresh < eia_pkg::ID_SPACE)
            begin
                r.granted = next_fresh;
                r.status  = eia_pkg::ST_CREATED;
                // The fresh id may already be live after the counter stepped back.
                if (!id_taken[next_fresh])
                begin
                    id_taken[next_fresh] = 1'b1;
                    live_cnt = live_cnt + 1'b1;
                end
                next_fresh = next_fresh + 1'b1;
            end
            else if (live_cnt < eia_pkg::ID_SPACE)
            begin
                found = 1'b0;
                for (int i = 0; i < eia_pkg::ID_SPACE; i++)
                begin
                    if (!found && !id_taken[i])
                    begin
                        found = 1'b1;
                        id_taken[i] = 1'b1;
                        live_cnt = live_cnt + 1'b1;
                        r.granted = eia_pkg::GRANT_W'(i);
                        r.status  = eia_pkg::ST_CREATED;
                    end
                end
            end
        end
        else if (!id_taken[target])
        begin
            r.status = eia_pkg::ST_ABSENT;
        end
        else
        begin
            higher = 1'b0;
            for (int i = int'(target) + 1; i < eia_pkg::ID_SPACE; i++)
            begin
                if (id_taken[i])
                begin
                    higher = 1'b1;
                end
            end
            if (!higher && next_fresh > 0)
            begin
                next_fresh = next_fresh - 1'b1;
            end
            id_taken[target] = 1'b0;
            if (live_cnt > 0)
            begin
                live_cnt = live_cnt - 1'b1;
            end
            r.status = eia_pkg::ST_DELETED;
        end
        r.live = live_cnt;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(input logic act, input logic [eia_pkg::TARGET_W-1:0] target);
        alloc_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = target;
        do
        begin
            @(posedge clk);
        end while (!s_axis_tready);
        predicted = predict_allocation(act, target);
        pending_results.insert(pending_results.size(), predicted);
        @(negedge clk);
    endtask

    function automatic logic [eia_pkg::TARGET_W-1:0] pick_live_id();
        int start;
        logic [eia_pkg::TARGET_W-1:0] pick;
        start = $urandom_range(eia_pkg::ID_SPACE - 1);
        pick = eia_pkg::TARGET_W'(start);
        for (int i = eia_pkg::ID_SPACE - 1; i >= 0; i--)
        begin
            if (id_taken[(start + i) % eia_pkg::ID_SPACE])
            begin
                pick = eia_pkg::TARGET_W'((start + i) % eia_pkg::ID_SPACE);
            end
        end
        return pick;
    endfunction

    function automatic logic [eia_pkg::TARGET_W-1:0] pick_highest_live();
        logic [eia_pkg::TARGET_W-1:0] pick;
        pick = eia_pkg::TARGET_W'($urandom_range(eia_pkg::ID_SPACE - 1));
        for (int i = 0; i < eia_pkg::ID_SPACE; i++)
        begin
            if (id_taken[i])
            begin
                pick = eia_pkg::TARGET_W'(i);
            end
        end
        return pick;
    endfunction

    task automatic test_directed_cases();
        send_request(ACT_DELETE, 8'd0);      // nothing live yet
        send_request(ACT_DELETE, 8'd255);
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_CREATE, 8'd255);    // target is ignored on create
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_DELETE, 8'd3);      // highest live id steps the counter back
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_DELETE, 8'd1);      // hole below the top
        send_request(ACT_DELETE, 8'd1);
        send_request(ACT_DELETE, 8'd200);
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_DELETE, 8'd4);
        send_request(ACT_DELETE, 8'd3);
        send_request(ACT_DELETE, 8'd2);
        send_request(ACT_DELETE, 8'd0);
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_DELETE, 8'hAA);
        send_request(ACT_DELETE, 8'h55);
        send_request(ACT_DELETE, 8'd1);
        send_request(ACT_DELETE, 8'd2);
    endtask

    task automatic test_fill_until_full();
        while (live_cnt < eia_pkg::ID_SPACE || next_fresh < eia_pkg::ID_SPACE)
        begin
            send_request(ACT_CREATE,
                         eia_pkg::TARGET_W'($urandom_range(eia_pkg::ID_SPACE - 1)));
        end
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_CREATE, 8'd255);
        send_request(ACT_DELETE, 8'd0);
        send_request(ACT_DELETE, 8'd128);
        send_request(ACT_DELETE, 8'd255);
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_CREATE, 8'd0);
        send_request(ACT_CREATE, 8'd0);
        repeat (20)
        begin
            send_request(ACT_DELETE, pick_live_id());
            send_request(ACT_CREATE,
                         eia_pkg::TARGET_W'($urandom_range(eia_pkg::ID_SPACE - 1)));
        end
    endtask

    // Runs of create-heavy, balanced and delete-heavy traffic, so the pool
    // both fills up and drains again.
    task automatic test_random_traffic(input int num_items);
        int create_pct;
        int run_left;
        int r;
        run_left = 0;
        create_pct = 50;
        for (int n = 0; n < num_items; n++)
        begin
            if (run_left == 0)
            begin
                run_left = $urandom_range(80, 20);
                case ($urandom_range(2))
                    0: create_pct = 90;
                    1: create_pct = 50;
                    default: create_pct = 15;
                endcase
            end
            run_left--;
            r = $urandom_range(99);
            if ($urandom_range(99) < create_pct)
            begin
                send_request(ACT_CREATE,
                             eia_pkg::TARGET_W'($urandom_range(eia_pkg::ID_SPACE - 1)));
            end
            else if (r < 65)
            begin
                send_request(ACT_DELETE, pick_live_id());
            end
            else if (r < 80)
            begin
                send_request(ACT_DELETE, pick_highest_live());
            end
            else
            begin
                send_request(ACT_DELETE,
                             eia_pkg::TARGET_W'($urandom_range(eia_pkg::ID_SPACE - 1)));
            end
        end
    endtask

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        alloc_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding: tdata %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[8:0] !== want.granted)
                begin
                    $error("granted_id: expected %0d, actual %0d", want.granted,
                           m_axis_tdata[8:0]);
                    error_count++;
                end
                if (m_axis_tdata[10:9] !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status,
                           m_axis_tdata[10:9]);
                    error_count++;
                end
                if (m_axis_tdata[19:11] !== want.live)
                begin
                    $error("live_total: expected %0d, actual %0d", want.live,
                           m_axis_tdata[19:11]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        id_taken   = '0;
        next_fresh = '0;
        live_cnt   = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct = 22;
        recv_idle_pct = 49;
        test_directed_cases();
        test_fill_until_full();
        test_random_traffic(550);
        send_idle_pct = 49;
        recv_idle_pct = 22;
        test_random_traffic(550);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(520);
        s_axis_tvalid = 1'b0;

        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== entity_id_allocator_top.f =====
rtl/core/eia_pkg.sv
rtl/core/eia_word_scan.sv
rtl/core/entity_id_allocator_top.sv
test/tb_entity_id_allocator_top.sv
